### hdl/p2h_pkg.sv
// ----------------------------------------------------------------------------
// p2h_pkg
// Shared widths, register indexes and the configuration bundle of the
// pixel to hex cell locator.
// ----------------------------------------------------------------------------
package p2h_pkg;

  localparam int PIX_W       = 16;
  localparam int SIZE_W      = 10;
  localparam int CUBE_W      = 18;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_WORD_W  = 3 * CUBE_W;

  // sqrt(3)/3 in Q0.32, rounded to nearest at the working fraction width later
  localparam logic [63:0] SQRT3_OVER_3_Q32 = 64'd2479700524;

  localparam logic [PIX_W-1:0]  ORIGIN_X_RST = 16'd250;
  localparam logic [PIX_W-1:0]  ORIGIN_Y_RST = 16'd200;
  localparam logic [SIZE_W-1:0] HEX_SIZE_RST = 10'd25;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ORIENT   = 3'd0,
    CFG_ORIGIN_X = 3'd1,
    CFG_ORIGIN_Y = 3'd2,
    CFG_HEX_W    = 3'd3,
    CFG_HEX_H    = 3'd4
  } cfg_idx_t;

  // hex sizes are held as the divisor actually used (zero already mapped to one)
  typedef struct packed {
    logic                    flat;
    logic signed [PIX_W-1:0] origin_x;
    logic signed [PIX_W-1:0] origin_y;
    logic [SIZE_W-1:0]       size_x;
    logic [SIZE_W-1:0]       size_y;
  } cfg_regs_t;

endpackage

### hdl/pixel_to_hex_cell_core.sv
// ----------------------------------------------------------------------------
// pixel_to_hex_cell_core
// Locates the hexagon that holds a pixel and returns its cube coordinate.
//
// in_*  stream: one pixel word per transfer (x low, y high, signed 16 bits).
// out_* stream: one cube coordinate word per pixel, in arrival order.
// cfg_* port  : write-only registers, index 0 orientation, 1/2 origin x/y,
//               3/4 hex width/height; written while no pixel is in flight.
// Throughput is one pixel per clock while the output buffer has a free entry.
// The divider retires one quotient bit per stage across FRACTION_BITS + 17
// stages, followed by nine stages of matrix, rounding and fix-up logic.
// A two-word output buffer follows the pipeline; the pipeline freezes only
// when both entries are full. A receiver stall parks the next word in the
// second entry, and in_tready then stays low from the following cycle until
// the cycle after the receiver takes a word again. Reset empties the
// pipeline and buffer and loads pointy-top, origin (250, 200) and a 25 by 25
// hex size.
// ----------------------------------------------------------------------------
module pixel_to_hex_cell_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [p2h_pkg::IN_TDATA_W-1:0]  in_tdata,   // pixel_x, pixel_y
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [p2h_pkg::OUT_TDATA_W-1:0] out_tdata,  // cube_x, cube_y, cube_z, 2 pad
  input  logic                            cfg_we,
  input  logic [p2h_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [p2h_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import p2h_pkg::*;

  localparam int NW = FRACTION_BITS + PIX_W + 1;

  cfg_regs_t         cfg;
  logic              en;
  logic              sc_vld, cb_vld;
  logic [NW-1:0]     ptx_mag, pty_mag;
  logic              ptx_neg, pty_neg;
  logic [CUBE_W-1:0] cube_x, cube_y, cube_z;
  logic [OUT_WORD_W-1:0] word_in;
  logic [OUT_WORD_W-1:0] head_r, tail_r;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push, pop;
  logic [CUBE_W-1:0] sum_chk;

  p2h_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  p2h_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .pixel_x (in_tdata[PIX_W-1:0]),
    .pixel_y (in_tdata[2*PIX_W-1:PIX_W]),
    .cfg     (cfg),
    .out_vld (sc_vld),
    .ptx_mag (ptx_mag),
    .ptx_neg (ptx_neg),
    .pty_mag (pty_mag),
    .pty_neg (pty_neg)
  );

  p2h_cube #(.FRACTION_BITS(FRACTION_BITS)) u_cube (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .flat    (cfg.flat),
    .in_vld  (sc_vld),
    .ptx_mag (ptx_mag),
    .ptx_neg (ptx_neg),
    .pty_mag (pty_mag),
    .pty_neg (pty_neg),
    .out_vld (cb_vld),
    .cube_x  (cube_x),
    .cube_y  (cube_y),
    .cube_z  (cube_z)
  );

  // whole pipeline moves while the output buffer has a free entry
  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;
  assign push      = en && cb_vld;
  assign pop       = out_tvalid && out_tready;
  assign word_in   = {cube_z, cube_y, cube_x};
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || cnt_r == 2'd0) begin
      head_r <= (cnt_r == 2'd2) ? tail_r : word_in;
    end
    if (push && !pop && cnt_r == 2'd1) begin
      tail_r <= word_in;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {{(OUT_TDATA_W-OUT_WORD_W){1'b0}}, head_r};

  assign sum_chk = head_r[CUBE_W-1:0] + head_r[2*CUBE_W-1:CUBE_W]
                 + head_r[3*CUBE_W-1:2*CUBE_W];

  a_cube_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (sum_chk == '0))
    else $error("cube coordinates do not sum to zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("buffer not empty after reset");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |=> (cnt_r != 2'd3) && (pop || cnt_r == 2'd2) || $past(pop))
    else $error("output buffer count out of range");

endmodule

### hdl/p2h_cfg_regs.sv
// ----------------------------------------------------------------------------
// p2h_cfg_regs
// Configuration register file: index decode, width trimming and the
// zero-size substitution for the two hex sizes.
// ----------------------------------------------------------------------------
module p2h_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [p2h_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [p2h_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output p2h_pkg::cfg_regs_t             cfg
);
  import p2h_pkg::*;

  cfg_regs_t         cfg_r;
  logic [SIZE_W-1:0] size_nxt;

  // a size of zero divides by one
  assign size_nxt = (cfg_wdata[SIZE_W-1:0] == '0) ? SIZE_W'(1) : cfg_wdata[SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flat     <= 1'b0;
      cfg_r.origin_x <= ORIGIN_X_RST;
      cfg_r.origin_y <= ORIGIN_Y_RST;
      cfg_r.size_x   <= HEX_SIZE_RST;
      cfg_r.size_y   <= HEX_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ORIENT:   cfg_r.flat     <= cfg_wdata[0];
        CFG_ORIGIN_X: cfg_r.origin_x <= cfg_wdata[PIX_W-1:0];
        CFG_ORIGIN_Y: cfg_r.origin_y <= cfg_wdata[PIX_W-1:0];
        CFG_HEX_W:    cfg_r.size_x   <= size_nxt;
        CFG_HEX_H:    cfg_r.size_y   <= size_nxt;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/p2h_scale.sv
// ----------------------------------------------------------------------------
// p2h_scale
// Origin subtract and division by the hex size for both axes, as a
// pipelined restoring divider that retires one quotient bit per stage.
// ----------------------------------------------------------------------------
module p2h_scale #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [p2h_pkg::PIX_W-1:0] pixel_x,
  input  logic signed [p2h_pkg::PIX_W-1:0] pixel_y,
  input  p2h_pkg::cfg_regs_t            cfg,
  output logic                          out_vld,
  output logic [FRACTION_BITS+16:0]     ptx_mag,
  output logic                          ptx_neg,
  output logic [FRACTION_BITS+16:0]     pty_mag,
  output logic                          pty_neg
);
  import p2h_pkg::*;

  localparam int F     = FRACTION_BITS;
  localparam int NW    = F + PIX_W + 1;
  localparam int DEPTH = NW;

  logic [DEPTH+1:0]         vld_r;
  logic [PIX_W:0]           d_r   [2];
  logic [DEPTH:0]           neg_r [2];
  logic [NW-1:0]            nq_r  [2][DEPTH+1];
  logic [SIZE_W-1:0]        rem_r [2][DEPTH+1];

  logic [SIZE_W-1:0]        den      [2];
  logic [NW-1:0]            num_nxt  [2];
  logic [SIZE_W-1:0]        rem_nxt  [2][DEPTH];
  logic                     qbit_nxt [2][DEPTH];

  assign den[0] = cfg.size_x;
  assign den[1] = cfg.size_y;

  always_comb begin
    logic [PIX_W:0]  dabs;
    logic [SIZE_W:0] pre;
    logic [SIZE_W:0] diff;
    for (int l = 0; l < 2; l++) begin
      dabs = d_r[l][PIX_W] ? (PIX_W+1)'(-d_r[l]) : d_r[l];
      // numerator with half the divisor added for round to nearest
      num_nxt[l] = {1'b0, dabs[PIX_W-1:0], {F{1'b0}}} + NW'(den[l] >> 1);
      for (int k = 0; k < DEPTH; k++) begin
        pre  = {rem_r[l][k], nq_r[l][k][NW-1]};
        diff = pre - {1'b0, den[l]};
        qbit_nxt[l][k] = (pre >= {1'b0, den[l]});
        rem_nxt[l][k]  = qbit_nxt[l][k] ? diff[SIZE_W-1:0] : pre[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= {pixel_x[PIX_W-1], pixel_x} - {cfg.origin_x[PIX_W-1], cfg.origin_x};
      d_r[1] <= {pixel_y[PIX_W-1], pixel_y} - {cfg.origin_y[PIX_W-1], cfg.origin_y};
      for (int l = 0; l < 2; l++) begin
        neg_r[l]    <= {neg_r[l][DEPTH-1:0], d_r[l][PIX_W]};
        nq_r[l][0]  <= num_nxt[l];
        rem_r[l][0] <= '0;
        // numerator bits shift out on top while quotient bits shift in below
        for (int k = 0; k < DEPTH; k++) begin
          nq_r[l][k+1]  <= {nq_r[l][k][NW-2:0], qbit_nxt[l][k]};
          rem_r[l][k+1] <= rem_nxt[l][k];
        end
      end
    end
  end

  assign out_vld = vld_r[DEPTH+1];
  assign ptx_mag = nq_r[0][DEPTH];
  assign ptx_neg = neg_r[0][DEPTH];
  assign pty_mag = nq_r[1][DEPTH];
  assign pty_neg = neg_r[1][DEPTH];

endmodule

### hdl/p2h_cube.sv
// ----------------------------------------------------------------------------
// p2h_cube
// Inverse layout matrix, rounding of the three cube coordinates and the
// fix-up of the coordinate with the largest rounding error.
// ----------------------------------------------------------------------------
module p2h_cube #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             flat,
  input  logic                             in_vld,
  input  logic [FRACTION_BITS+16:0]        ptx_mag,
  input  logic                             ptx_neg,
  input  logic [FRACTION_BITS+16:0]        pty_mag,
  input  logic                             pty_neg,
  output logic                             out_vld,
  output logic [p2h_pkg::CUBE_W-1:0]       cube_x,
  output logic [p2h_pkg::CUBE_W-1:0]       cube_y,
  output logic [p2h_pkg::CUBE_W-1:0]       cube_z
);
  import p2h_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int NW = F + PIX_W + 1;
  localparam int PW = NW + F;
  localparam int MW = NW + 1;
  localparam int VW = F + 21;
  localparam int RW = CUBE_W + 1;

  localparam logic [F-1:0] HALF  = {1'b1, {(F-1){1'b0}}};
  localparam logic [F-1:0] THIRD = F'(((64'd1 << F) + 64'd1) / 64'd3);
  localparam logic [F-1:0] TWO3  = F'(((64'd1 << (F + 1)) + 64'd1) / 64'd3);
  localparam logic [F-1:0] S3    = F'((SQRT3_OVER_3_Q32 + (64'd1 << (31 - F))) >> (32 - F));

  logic [8:0] vld_r;

  // C1 products, C2 rounded magnitudes, C3 signed terms
  logic [PW-1:0]        pa_r, pb_r, pc_r;
  logic [2:0]           sgn1_r, sgn2_r;
  logic [MW-1:0]        ma_r, mb_r, mc_r;
  logic signed [VW-1:0] ta_r, tb_r, tc_r;
  // C4 fx fy, C5 fz
  logic signed [VW-1:0] fx4_r, fy4_r;
  logic signed [VW-1:0] fx5_r, fy5_r, fz5_r;
  // C6 rounded values, C7 errors, C8 fix-up choice
  logic signed [RW-1:0] rx6_r, ry6_r, rz6_r;
  logic [F:0]           vx6_r, vy6_r, vz6_r;
  logic signed [RW-1:0] rx7_r, ry7_r, rz7_r;
  logic [F-1:0]         ex_r, ey_r, ez_r;
  logic signed [RW-1:0] rx8_r, ry8_r, rz8_r;
  logic                 fix_x_r, fix_y_r;
  logic [CUBE_W-1:0]    cx_r, cy_r, cz_r;

  logic [NW-1:0]        opb;
  logic [F-1:0]         ca, cc;
  logic [PW:0]          ra, rb, rc;
  logic signed [VW-1:0] sx, sy, sz;
  logic [F:0]           dx, dy, dz;
  logic [F:0]           ax, ay, az;
  logic signed [RW-1:0] alt_x, alt_y, alt_z;

  // pointy: x = s*ptx - t*pty, y = (2/3)*pty ; flat: x = (2/3)*ptx, y = s*pty - t*ptx
  assign ca  = flat ? TWO3 : S3;
  assign cc  = flat ? S3 : TWO3;
  assign opb = flat ? ptx_mag : pty_mag;

  assign ra = {1'b0, pa_r} + (PW+1)'(HALF);
  assign rb = {1'b0, pb_r} + (PW+1)'(HALF);
  assign rc = {1'b0, pc_r} + (PW+1)'(HALF);

  // round half away from zero: negative values add one less
  assign sx = fx5_r + VW'(HALF) - VW'(fx5_r[VW-1]);
  assign sy = fy5_r + VW'(HALF) - VW'(fy5_r[VW-1]);
  assign sz = fz5_r + VW'(HALF) - VW'(fz5_r[VW-1]);

  // rounding error only needs the low bits, it never exceeds half
  assign dx = {rx6_r[0], {F{1'b0}}} - vx6_r;
  assign dy = {ry6_r[0], {F{1'b0}}} - vy6_r;
  assign dz = {rz6_r[0], {F{1'b0}}} - vz6_r;
  assign ax = dx[F] ? (F+1)'(0) - dx : dx;
  assign ay = dy[F] ? (F+1)'(0) - dy : dy;
  assign az = dz[F] ? (F+1)'(0) - dz : dz;

  assign alt_x = -ry8_r - rz8_r;
  assign alt_y = -rx8_r - rz8_r;
  assign alt_z = -rx8_r - ry8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[7:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r   <= PW'(ptx_mag) * PW'(ca);
      pb_r   <= PW'(opb) * PW'(THIRD);
      pc_r   <= PW'(pty_mag) * PW'(cc);
      sgn1_r <= {pty_neg, ~(flat ? ptx_neg : pty_neg), ptx_neg};

      ma_r   <= ra[PW:F];
      mb_r   <= rb[PW:F];
      mc_r   <= rc[PW:F];
      sgn2_r <= sgn1_r;

      ta_r <= sgn2_r[0] ? -VW'(ma_r) : VW'(ma_r);
      tb_r <= sgn2_r[1] ? -VW'(mb_r) : VW'(mb_r);
      tc_r <= sgn2_r[2] ? -VW'(mc_r) : VW'(mc_r);

      fx4_r <= flat ? ta_r : ta_r + tb_r;
      fy4_r <= flat ? tb_r + tc_r : tc_r;

      fx5_r <= fx4_r;
      fy5_r <= fy4_r;
      fz5_r <= -fx4_r - fy4_r;

      rx6_r <= sx[F+RW-1:F];
      ry6_r <= sy[F+RW-1:F];
      rz6_r <= sz[F+RW-1:F];
      vx6_r <= fx5_r[F:0];
      vy6_r <= fy5_r[F:0];
      vz6_r <= fz5_r[F:0];

      rx7_r <= rx6_r;
      ry7_r <= ry6_r;
      rz7_r <= rz6_r;
      ex_r  <= ax[F-1:0];
      ey_r  <= ay[F-1:0];
      ez_r  <= az[F-1:0];

      // ties go to z over x and y, and to y over x
      rx8_r   <= rx7_r;
      ry8_r   <= ry7_r;
      rz8_r   <= rz7_r;
      fix_x_r <= (ex_r > ey_r) && (ex_r > ez_r);
      fix_y_r <= !((ex_r > ey_r) && (ex_r > ez_r)) && (ey_r > ez_r);

      cx_r <= fix_x_r ? alt_x[CUBE_W-1:0] : rx8_r[CUBE_W-1:0];
      cy_r <= fix_y_r ? alt_y[CUBE_W-1:0] : ry8_r[CUBE_W-1:0];
      cz_r <= (!fix_x_r && !fix_y_r) ? alt_z[CUBE_W-1:0] : rz8_r[CUBE_W-1:0];
    end
  end

  assign out_vld = vld_r[8];
  assign cube_x  = cx_r;
  assign cube_y  = cy_r;
  assign cube_z  = cz_r;

  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[6] |-> (ex_r <= HALF) && (ey_r <= HALF) && (ez_r <= HALF))
    else $error("rounding error beyond half a unit");

endmodule

### tb/tb_pixel_to_hex_cell_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_to_hex_cell_core
// Streams pixels through the hex locator under a series of grid settings and
// checks every cube coordinate word against an in-bench fixed point model of
// the scaling, inverse layout matrix, rounding and largest-error fix-up.
// ----------------------------------------------------------------------------
module tb_pixel_to_hex_cell_core;
  import p2h_pkg::*;

  localparam int FB          = 16;
  localparam int TAIL_CYCLES = FB + 48;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_REPORTS = 20;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 173;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_TOP = '1;

  typedef enum logic [1:0] {FIX_X, FIX_Y, FIX_Z} fix_axis_t;

  typedef struct {
    logic signed [CUBE_W-1:0] x;
    logic signed [CUBE_W-1:0] y;
    logic signed [CUBE_W-1:0] z;
    fix_axis_t                fixed;
  } hex_pos_t;

  typedef struct {
    logic                    flat;
    logic signed [PIX_W-1:0] origin_x;
    logic signed [PIX_W-1:0] origin_y;
    logic [SIZE_W-1:0]       hex_w;
    logic [SIZE_W-1:0]       hex_h;
  } grid_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  grid_t    grid;
  hex_pos_t pending_hexes[$];
  int       errors = 0;
  int       pixels_sent = 0;
  int       flat_pixels = 0;
  int       grid_settings = 0;
  int       fix_count[3] = '{0, 0, 0};
  int       burst_left = 0;
  int       idle_cycles = 0;
  bit       tx_steady = 1'b0;
  bit       rx_steady = 1'b0;
  logic [15:0] stall_bits = '0;
  int       stall_pos = 0;

  pixel_to_hex_cell_core #(.FRACTION_BITS(FB)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // pixel_x, pixel_y
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // cube_x, cube_y, cube_z, pad
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- fixed point model ----------------

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // num * 2^FB / den, nearest, halves away from zero
  function automatic longint scale_to_q(longint num, longint den);
    longint q;
    q = ((mag(num) <<< FB) + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint mul_const(longint a, longint c, bit neg);
    longint r;
    r = (mag(a) * c + (64'sd1 <<< (FB - 1))) >>> FB;
    return ((a < 0) != neg) ? -r : r;
  endfunction

  function automatic longint round_whole(longint v);
    longint r;
    r = (mag(v) + (64'sd1 <<< (FB - 1))) >>> FB;
    return v < 0 ? -r : r;
  endfunction

  function automatic hex_pos_t hex_of_pixel(logic signed [PIX_W-1:0] px,
                                            logic signed [PIX_W-1:0] py);
    longint third, two_thirds, s3, w, h, ptx, pty;
    longint fx, fy, fz, rx, ry, rz, ex, ey, ez;
    hex_pos_t res;
    third      = ((64'sd1 <<< FB) + 1) / 3;
    two_thirds = ((64'sd1 <<< (FB + 1)) + 1) / 3;
    s3 = (longint'(SQRT3_OVER_3_Q32) + (64'sd1 <<< (31 - FB))) >>> (32 - FB);
    w = (grid.hex_w == 0) ? 1 : longint'(grid.hex_w);
    h = (grid.hex_h == 0) ? 1 : longint'(grid.hex_h);
    ptx = scale_to_q(longint'(px) - longint'(grid.origin_x), w);
    pty = scale_to_q(longint'(py) - longint'(grid.origin_y), h);
    if (grid.flat) begin
      fx = mul_const(ptx, two_thirds, 1'b0);
      fy = mul_const(ptx, third, 1'b1) + mul_const(pty, s3, 1'b0);
    end else begin
      fx = mul_const(ptx, s3, 1'b0) + mul_const(pty, third, 1'b1);
      fy = mul_const(pty, two_thirds, 1'b0);
    end
    fz = -fx - fy;
    rx = round_whole(fx);
    ry = round_whole(fy);
    rz = round_whole(fz);
    ex = mag((rx <<< FB) - fx);
    ey = mag((ry <<< FB) - fy);
    ez = mag((rz <<< FB) - fz);
    // coordinate farthest from its rounded value is rebuilt; ties favor z over x and y, and y over x
    if (ex > ey && ex > ez) begin
      rx = -ry - rz;
      res.fixed = FIX_X;
    end else if (ey > ez) begin
      ry = -rx - rz;
      res.fixed = FIX_Y;
    end else begin
      rz = -rx - ry;
      res.fixed = FIX_Z;
    end
    res.x = rx[CUBE_W-1:0];
    res.y = ry[CUBE_W-1:0];
    res.z = rz[CUBE_W-1:0];
    return res;
  endfunction

  // ---------------- result checker and receiver stalls ----------------

  task automatic compare_axis(string axis, logic signed [CUBE_W-1:0] want,
                              logic signed [CUBE_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: cube_%s mismatch, expected %0d, got %0d", $time, axis, want, got);
    end
  endtask

  task automatic check_hex;
    hex_pos_t want;
    if (pending_hexes.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: unexpected word, expected none, got %h", $time, out_tdata);
    end else begin
      want = pending_hexes.pop_front();
      compare_axis("x", want.x, out_tdata[0 +: CUBE_W]);
      compare_axis("y", want.y, out_tdata[CUBE_W +: CUBE_W]);
      compare_axis("z", want.z, out_tdata[2*CUBE_W +: CUBE_W]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        check_hex();
      if (stall_pos == 0)
        stall_bits = ($urandom_range(0, 1) != 0) ? 16'($urandom & $urandom) : 16'($urandom);
      out_tready <= rx_steady || !stall_bits[stall_pos];
      stall_pos = (stall_pos + 1) % 16;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- drivers ----------------

  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
    int gap;
    if (burst_left == 0) begin
      gap = tx_steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {py, px};
    do @(posedge clk); while (!in_tready);
    pending_hexes.insert(pending_hexes.size(), hex_of_pixel(px, py));
    fix_count[pending_hexes[$].fixed]++;
    pixels_sent++;
    if (grid.flat)
      flat_pixels++;
    burst_left--;
  endtask

  // lower valid and wait for every outstanding word
  task automatic drain;
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_hexes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_ORIENT:   grid.flat     = data[0];
      CFG_ORIGIN_X: grid.origin_x = data[PIX_W-1:0];
      CFG_ORIGIN_Y: grid.origin_y = data[PIX_W-1:0];
      CFG_HEX_W:    grid.hex_w    = data[SIZE_W-1:0];
      CFG_HEX_H:    grid.hex_h    = data[SIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic end_writes;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(logic [15:0] orient, logic [15:0] ox, logic [15:0] oy,
                          logic [15:0] hw, logic [15:0] hh);
    write_reg(CFG_ORIENT, orient);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_HEX_W, hw);
    write_reg(CFG_HEX_H, hh);
    end_writes();
    grid_settings++;
  endtask

  task automatic write_unused(logic [15:0] data);
    write_reg(CFG_ADDR_W'($urandom_range(CFG_HEX_H + 1, CFG_IDX_TOP)), data);
    end_writes();
  endtask

  // ---------------- tests ----------------

  task automatic test_reset_grid;
    send_pixel(16'd250, 16'd200);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'h8000, 16'h8000);
    send_pixel(16'h7FFF, 16'h7FFF);
    send_pixel(16'h8000, 16'h7FFF);
    send_pixel(16'h7FFF, 16'h8000);
    send_pixel(16'd262, 16'd200);
    send_pixel(16'd250, 16'd213);
    drain();
  endtask

  task automatic test_register_edges;
    // flat with upper bits set, minimum origin, zero sizes behave as one
    set_grid(16'hFFFF, 16'h8000, 16'h8000, 16'h0000, 16'hFC00);
    send_pixel(16'h7FFF, 16'h7FFF);
    send_pixel(16'h8000, 16'h8000);
    send_pixel(16'h0000, 16'h7FFF);
    drain();
    // pointy, maximum origin, largest sizes
    set_grid(16'hFFFE, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h03FF);
    send_pixel(16'h8000, 16'h8000);
    send_pixel(16'h7FFF, 16'h7FFF);
    send_pixel(16'h0000, 16'h0000);
    drain();
    set_grid(16'h0001, 16'h7FFF, 16'h8000, 16'h0001, 16'h0001);
    send_pixel(16'h8000, 16'h7FFF);
    send_pixel(16'h7FFF, 16'h8000);
    drain();
    // writes past the last register must leave the grid alone
    write_unused(16'hFFFF);
    send_pixel(16'd1234, 16'hFDC9);
    drain();
  endtask

  task automatic test_rounding_ties;
    set_grid(16'h0000, 16'h0000, 16'h0000, 16'h0002, 16'h0002);
    send_pixel(16'd1, 16'd1);
    send_pixel(16'hFFFF, 16'd1);
    send_pixel(16'd1, 16'hFFFF);
    drain();
    set_grid(16'h0001, 16'h0000, 16'h0000, 16'h0003, 16'h0003);
    send_pixel(16'd1, 16'd2);
    send_pixel(16'hFFFE, 16'hFFFF);
    send_pixel(16'd3, 16'h0000);
    drain();
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return 16'($urandom_range(0, 63)) << SIZE_W;  // zero after masking
    else if (r <= 2)
      return 16'($urandom);
    else
      return 16'($urandom_range(1, 64));
  endfunction

  function automatic logic [15:0] pick_origin();
    if ($urandom_range(0, 1) != 0)
      return 16'(int'($urandom_range(0, 2000)) - 1000);
    else
      return 16'($urandom);
  endfunction

  task automatic test_random_grid;
    int span_x, span_y;
    logic [15:0] px, py;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      set_grid(16'($urandom), pick_origin(), pick_origin(), pick_size(), pick_size());
      if ($urandom_range(0, 2) == 0)
        write_unused(16'($urandom));
      span_x = (grid.hex_w == 0) ? 4 : 4 * grid.hex_w;
      span_y = (grid.hex_h == 0) ? 4 : 4 * grid.hex_h;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // mostly a few hexes around the origin, where the rounding decisions live
        if ($urandom_range(0, 3) != 0) begin
          px = 16'(int'(grid.origin_x) + int'($urandom_range(0, 2 * span_x)) - span_x);
          py = 16'(int'(grid.origin_y) + int'($urandom_range(0, 2 * span_y)) - span_y);
        end else begin
          px = 16'($urandom);
          py = 16'($urandom);
        end
        send_pixel(px, py);
      end
      drain();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    grid.flat     = 1'b0;
    grid.origin_x = ORIGIN_X_RST;
    grid.origin_y = ORIGIN_Y_RST;
    grid.hex_w    = HEX_SIZE_RST;
    grid.hex_h    = HEX_SIZE_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_grid();
    test_register_edges();
    test_rounding_ties();
    test_random_grid();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("located %0d pixels (%0d flat-top) over %0d grid settings plus reset values",
             pixels_sent, flat_pixels, grid_settings);
    $display("rebuilt axis x/y/z: %0d/%0d/%0d, mismatches: %0d",
             fix_count[FIX_X], fix_count[FIX_Y], fix_count[FIX_Z], errors);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
